@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/tic_pkg.sv @@
// ----------------------------------------------------------------------------
// tic_pkg
// Types and constants shared by the timer / interrupt controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tic_pkg;

    localparam int DIVIDER_PERIOD_DEFAULT = 256;
    localparam int QUEUE_DEPTH            = 2;

    localparam int CYCLES_W   = 6;
    localparam int IRQ_W      = 5;
    localparam int PC_W       = 16;
    localparam int COUNT_W    = 8;
    localparam int PERIOD_W   = 11;
    localparam int IRQ_IDX_W  = 3;

    localparam logic [PERIOD_W-1:0] TIMER_PERIOD_RESET = 11'd1024;
    localparam logic [COUNT_W-1:0]  VECTOR_BASE        = 8'h40;
    localparam int                  TIMER_IRQ_BIT      = 2;

    typedef enum logic [1:0] {
        REG_TIMER_PERIOD     = 2'd0,
        REG_TIMER_ENABLE     = 2'd1,
        REG_TIMER_RELOAD     = 2'd2,
        REG_INTERRUPT_ENABLE = 2'd3
    } tic_reg_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                enable;
        logic [COUNT_W-1:0]  reload;
    } tic_timer_cfg_t;

    // classified item handed from the timer front to the dispatch back
    typedef struct packed {
        logic [PC_W-1:0]    pc;
        logic               set_me;
        logic [IRQ_W-1:0]   ext;
        logic               timer_irq;
        logic [COUNT_W-1:0] divider_value;
        logic [COUNT_W-1:0] timer_value;
    } tic_item_t;

    typedef struct packed {
        logic [IRQ_W-1:0]   pending_flags;
        logic [COUNT_W-1:0] divider_value;
        logic [COUNT_W-1:0] timer_value;
        logic               wake;
        logic [PC_W-1:0]    return_address;
        logic [COUNT_W-1:0] vector;
        logic               service;
    } tic_result_t;

endpackage

`default_nettype wire

@@ design/timer_interrupt_controller.sv @@
// ----------------------------------------------------------------------------
// timer_interrupt_controller
// Timer, divider and interrupt dispatch, one transaction per instruction.
//
//   Channel   Dir   Handshake                  Payload
//   s_*       in    s_tvalid / s_tready        cycles, ext_requests, set_me, pc
//   m_*       out   m_tvalid / m_tready        service .. pending_flags
//   APB       in    psel & penable & pwrite    timer_period .. interrupt_enable
//
// One transaction per cycle sustained while m_tready stays high; the front
// writes each into the queue, the back moves it into the output register.
// The timer front computes its per-item accumulator loop combinationally.
// rst_n clears all counters, flags and the master enable asynchronously.
// s_tready drops only on a full queue, after the output register was held.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module timer_interrupt_controller #(
    parameter int DIVIDER_PERIOD = tic_pkg::DIVIDER_PERIOD_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // cycles[5:0] ext_requests[10:6] set_master_enable[11]
                                   // current_pc[27:12] zero[31:28]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // service[0] vector[8:1] return_address[24:9] wake[25]
                                   // timer_value[33:26] divider_value[41:34]
                                   // pending_flags[46:42] zero[47]
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tic_pkg::*;

    tic_timer_cfg_t    timer_cfg_reg;
    logic [IRQ_W-1:0]  ie_reg;
    tic_reg_t          reg_sel;
    logic              cfg_write;

    logic              push;
    logic              q_not_full;
    logic              q_not_empty;
    logic              pop;
    tic_item_t         push_item;
    tic_item_t         head;
    tic_result_t       result;

    assign pready    = 1'b1;
    assign reg_sel   = tic_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_cfg_reg.period <= TIMER_PERIOD_RESET;
            timer_cfg_reg.enable <= 1'b0;
            timer_cfg_reg.reload <= '0;
            ie_reg               <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_TIMER_PERIOD:     timer_cfg_reg.period <= pwdata[PERIOD_W-1:0];
                REG_TIMER_ENABLE:     timer_cfg_reg.enable <= pwdata[0];
                REG_TIMER_RELOAD:     timer_cfg_reg.reload <= pwdata[COUNT_W-1:0];
                REG_INTERRUPT_ENABLE: ie_reg               <= pwdata[IRQ_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_TIMER_PERIOD:     prdata = 32'(timer_cfg_reg.period);
            REG_TIMER_ENABLE:     prdata = 32'(timer_cfg_reg.enable);
            REG_TIMER_RELOAD:     prdata = 32'(timer_cfg_reg.reload);
            REG_INTERRUPT_ENABLE: prdata = 32'(ie_reg);
            default:              prdata = '0;
        endcase
    end

    assign s_tready = q_not_full;

    tic_front #(
        .DIVIDER_PERIOD (DIVIDER_PERIOD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .timer_cfg  (timer_cfg_reg),
        .in_valid   (s_tvalid),
        .in_cycles  (s_tdata[5:0]),
        .in_ext     (s_tdata[10:6]),
        .in_set_me  (s_tdata[11]),
        .in_pc      (s_tdata[27:12]),
        .push_ready (q_not_full),
        .push       (push),
        .push_item  (push_item)
    );

    tic_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    tic_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .interrupt_enable (ie_reg),
        .head_valid       (q_not_empty),
        .head             (head),
        .pop              (pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_result       (result)
    );

    assign m_tdata = {1'b0, result};

    `ASSERT_IMPLY(a_service_wakes, m_tvalid && m_tdata[0], m_tdata[25],
        "service without wake")
    `ASSERT_IMPLY(a_vector_legal, m_tvalid && m_tdata[0],
        (m_tdata[8:1] == 8'h40) || (m_tdata[8:1] == 8'h48) || (m_tdata[8:1] == 8'h50) ||
        (m_tdata[8:1] == 8'h58) || (m_tdata[8:1] == 8'h60),
        "illegal interrupt vector")
    `ASSERT_IMPLY(a_idle_vector_zero, m_tvalid && !m_tdata[0],
        (m_tdata[8:1] == 8'h00) && (m_tdata[24:9] == 16'h0000),
        "vector or return address set without service")
    `ASSERT_ALWAYS(a_full_queue_held, s_tready || m_tvalid,
        "queue full while output register empty")

endmodule

`default_nettype wire

@@ design/tic_front.sv @@
// ----------------------------------------------------------------------------
// tic_front
// Input side: advances timer and divider per accepted transaction and
// emits a classified item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tic_front #(
    parameter int DIVIDER_PERIOD = tic_pkg::DIVIDER_PERIOD_DEFAULT
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  tic_pkg::tic_timer_cfg_t       timer_cfg,
    input  wire                           in_valid,
    input  wire  [tic_pkg::CYCLES_W-1:0]  in_cycles,
    input  wire  [tic_pkg::IRQ_W-1:0]     in_ext,
    input  wire                           in_set_me,
    input  wire  [tic_pkg::PC_W-1:0]      in_pc,
    input  wire                           push_ready,
    output logic                          push,
    output tic_pkg::tic_item_t            push_item
);
    import tic_pkg::*;

    localparam int DIV_ACC_W = (DIVIDER_PERIOD >= 64) ? $clog2(DIVIDER_PERIOD + 64) : 16;
    localparam logic [DIV_ACC_W-1:0] DIV_PERIOD_V = DIV_ACC_W'(DIVIDER_PERIOD);

    logic [PERIOD_W-1:0]  timer_acc_reg,  timer_acc_next;
    logic [DIV_ACC_W-1:0] div_acc_reg,    div_acc_next;
    logic [COUNT_W-1:0]   timer_cnt_reg,  timer_cnt_next;
    logic [COUNT_W-1:0]   div_cnt_reg,    div_cnt_next;

    logic [PERIOD_W:0]    t_sum;
    logic [PERIOD_W-1:0]  t_sat;
    logic [DIV_ACC_W:0]   d_sum;
    logic [DIV_ACC_W-1:0] d_sat;
    logic                 timer_irq;

    always_comb
    begin
        t_sum = {1'b0, timer_acc_reg} + (PERIOD_W+1)'(in_cycles);
        t_sat = t_sum[PERIOD_W] ? {PERIOD_W{1'b1}} : t_sum[PERIOD_W-1:0];
        timer_acc_next = timer_acc_reg;
        timer_cnt_next = timer_cnt_reg;
        timer_irq      = 1'b0;
        if (timer_cfg.enable)
        begin
            timer_acc_next = t_sat;
            if (t_sat >= timer_cfg.period)
            begin
                timer_acc_next = t_sat - timer_cfg.period;
                if (timer_cnt_reg == {COUNT_W{1'b1}})
                begin
                    timer_cnt_next = timer_cfg.reload;
                    timer_irq      = 1'b1;
                end
                else
                begin
                    timer_cnt_next = timer_cnt_reg + 1'b1;
                end
            end
        end

        d_sum = {1'b0, div_acc_reg} + (DIV_ACC_W+1)'(in_cycles);
        d_sat = d_sum[DIV_ACC_W] ? {DIV_ACC_W{1'b1}} : d_sum[DIV_ACC_W-1:0];
        div_acc_next = d_sat;
        div_cnt_next = div_cnt_reg;
        if (d_sat >= DIV_PERIOD_V)
        begin
            div_acc_next = d_sat - DIV_PERIOD_V;
            div_cnt_next = div_cnt_reg + 1'b1;
        end
    end

    assign push = in_valid && push_ready;

    always_comb
    begin
        push_item.pc            = in_pc;
        push_item.set_me        = in_set_me;
        push_item.ext           = in_ext;
        push_item.timer_irq     = timer_irq;
        push_item.divider_value = div_cnt_next;
        push_item.timer_value   = timer_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_acc_reg <= '0;
            div_acc_reg   <= '0;
            timer_cnt_reg <= '0;
            div_cnt_reg   <= '0;
        end
        else if (push)
        begin
            timer_acc_reg <= timer_acc_next;
            div_acc_reg   <= div_acc_next;
            timer_cnt_reg <= timer_cnt_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ design/tic_queue.sv @@
// ----------------------------------------------------------------------------
// tic_queue
// Short register FIFO decoupling the timer front from the dispatch back.
// ----------------------------------------------------------------------------
`default_nettype none

module tic_queue #(
    parameter int DEPTH = tic_pkg::QUEUE_DEPTH
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  tic_pkg::tic_item_t  push_item,
    output logic                not_full,
    input  wire                 pop,
    output logic                not_empty,
    output tic_pkg::tic_item_t  head
);
    import tic_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tic_item_t          store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign not_full  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/tic_back.sv @@
// ----------------------------------------------------------------------------
// tic_back
// Output side: merges requests into the flags, dispatches the lowest
// pending interrupt and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tic_back (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  [tic_pkg::IRQ_W-1:0]    interrupt_enable,
    input  wire                          head_valid,
    input  tic_pkg::tic_item_t           head,
    output logic                         pop,
    output logic                         out_valid,
    input  wire                          out_ready,
    output tic_pkg::tic_result_t         out_result
);
    import tic_pkg::*;

    logic [IRQ_W-1:0]     flags_reg, flags_next;
    logic                 me_reg,    me_next;
    logic                 out_valid_reg;
    tic_result_t          result_reg;
    tic_result_t          result_next;

    logic [IRQ_W-1:0]     merged;
    logic [IRQ_W-1:0]     pending;
    logic [IRQ_W-1:0]     grant;
    logic [IRQ_IDX_W-1:0] grant_idx;
    logic                 me_now;
    logic                 service;

    always_comb
    begin
        merged = flags_reg | head.ext;
        merged[TIMER_IRQ_BIT] = merged[TIMER_IRQ_BIT] | head.timer_irq;
        me_now  = me_reg | head.set_me;
        pending = merged & interrupt_enable;

        grant     = '0;
        grant_idx = '0;
        for (int i = IRQ_W - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                grant     = '0;
                grant[i]  = 1'b1;
                grant_idx = IRQ_IDX_W'(i);
            end
        end

        service    = (pending != '0) && me_now;
        flags_next = service ? (merged & ~grant) : merged;
        me_next    = service ? 1'b0 : me_now;

        result_next.service        = service;
        result_next.vector         = service ? (VECTOR_BASE + COUNT_W'({grant_idx, 3'b000}))
                                             : '0;
        result_next.return_address = service ? head.pc : '0;
        result_next.wake           = (pending != '0);
        result_next.timer_value    = head.timer_value;
        result_next.divider_value  = head.divider_value;
        result_next.pending_flags  = flags_next;
    end

    assign pop        = head_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            me_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                flags_reg <= flags_next;
                me_reg    <= me_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sim/tic_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tic_checker
// Watches the APB port and both stream channels of the timer / interrupt
// controller. Keeps its own copy of the timer, divider and interrupt state,
// predicts the result of every accepted transaction and compares it field by
// field with the results that leave the block, oldest first.
// ----------------------------------------------------------------------------
module tic_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [31:0] s_tdata,   // cycles[5:0] ext_requests[10:6] set_master_enable[11]
                                   // current_pc[27:12] zero[31:28]
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [47:0] m_tdata,   // service[0] vector[8:1] return_address[24:9] wake[25]
                                   // timer_value[33:26] divider_value[41:34]
                                   // pending_flags[46:42] zero[47]
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    output int          errors,
    output int          outstanding,
    output int          results_seen,
    output int          services_seen,
    output int          overflows_seen
);
    import tic_pkg::*;

    localparam int          DIV_PERIOD = DIVIDER_PERIOD_DEFAULT;
    localparam logic [11:0] ACC_SAT    = 12'd2047;

    // register copies
    logic [PERIOD_W-1:0] cfg_period;
    logic                cfg_enable;
    logic [COUNT_W-1:0]  cfg_reload;
    logic [IRQ_W-1:0]    cfg_irq_en;

    // controller state
    logic [PERIOD_W-1:0] tmr_acc;
    logic [8:0]          div_acc;
    logic [COUNT_W-1:0]  tmr_cnt;
    logic [COUNT_W-1:0]  div_cnt;
    logic [IRQ_W-1:0]    irq_flags;
    logic                ime;

    tic_result_t expected_results[$];
    tic_result_t got;
    tic_result_t want;

    task automatic report_mismatch(string what, int got_v, int want_v);
        $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h", $time, what, got_v, want_v);
        errors++;
    endtask

    task automatic check_field(string what, int got_v, int want_v);
        if (got_v != want_v)
            report_mismatch(what, got_v, want_v);
    endtask

    task automatic apply_write(logic [3:0] addr, logic [31:0] data);
        case (tic_reg_t'(addr[3:2]))
            REG_TIMER_PERIOD:     cfg_period = data[PERIOD_W-1:0];
            REG_TIMER_ENABLE:     cfg_enable = data[0];
            REG_TIMER_RELOAD:     cfg_reload = data[COUNT_W-1:0];
            REG_INTERRUPT_ENABLE: cfg_irq_en = data[IRQ_W-1:0];
            default: ;
        endcase
    endtask

    function automatic tic_result_t predict_dispatch(logic [CYCLES_W-1:0] cyc,
                                                     logic [IRQ_W-1:0] ext,
                                                     logic sme,
                                                     logic [PC_W-1:0] pc);
        logic [11:0]      tsum;
        logic [9:0]       dsum;
        logic [IRQ_W-1:0] pend;
        logic             found;
        tic_result_t      r;
        r = '0;
        if (cfg_enable)
        begin
            tsum = {1'b0, tmr_acc} + 12'(cyc);
            if (tsum > ACC_SAT)
                tsum = ACC_SAT;
            if (tsum >= {1'b0, cfg_period})
            begin
                tsum = tsum - {1'b0, cfg_period};
                if (tmr_cnt == 8'hFF)
                begin
                    tmr_cnt = cfg_reload;
                    irq_flags[TIMER_IRQ_BIT] = 1'b1;
                    overflows_seen++;
                end
                else
                begin
                    tmr_cnt = tmr_cnt + 8'd1;
                end
            end
            tmr_acc = tsum[PERIOD_W-1:0];
        end
        dsum = {1'b0, div_acc} + 10'(cyc);
        if (dsum >= 10'(DIV_PERIOD))
        begin
            dsum = dsum - 10'(DIV_PERIOD);
            div_cnt = div_cnt + 8'd1;
        end
        div_acc = dsum[8:0];

        irq_flags = irq_flags | ext;
        if (sme)
            ime = 1'b1;
        pend = irq_flags & cfg_irq_en;
        if (pend != '0)
        begin
            r.wake = 1'b1;
            if (ime)
            begin
                found = 1'b0;
                for (int b = 0; b < IRQ_W; b++)
                begin
                    if (!found && pend[b])
                    begin
                        found = 1'b1;
                        irq_flags[b] = 1'b0;
                        r.vector = VECTOR_BASE + 8'(8 * b);
                    end
                end
                ime = 1'b0;
                r.service = 1'b1;
                r.return_address = pc;
            end
        end
        r.timer_value   = tmr_cnt;
        r.divider_value = div_cnt;
        r.pending_flags = irq_flags;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_period     = TIMER_PERIOD_RESET;
            cfg_enable     = 1'b0;
            cfg_reload     = '0;
            cfg_irq_en     = '0;
            tmr_acc        = '0;
            div_acc        = '0;
            tmr_cnt        = '0;
            div_cnt        = '0;
            irq_flags      = '0;
            ime            = 1'b0;
            errors         = 0;
            outstanding    = 0;
            results_seen   = 0;
            services_seen  = 0;
            overflows_seen = 0;
            expected_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                apply_write(paddr, pwdata);
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_dispatch(s_tdata[5:0], s_tdata[10:6],
                                                            s_tdata[11], s_tdata[27:12]));
            if (m_tvalid && m_tready)
            begin
                got = tic_result_t'(m_tdata[46:0]);
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with no transaction waiting", int'(m_tdata), 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.service)
                        services_seen++;
                    check_field("service", got.service, want.service);
                    check_field("vector", got.vector, want.vector);
                    check_field("return_address", got.return_address, want.return_address);
                    check_field("wake", got.wake, want.wake);
                    check_field("timer_value", got.timer_value, want.timer_value);
                    check_field("divider_value", got.divider_value, want.divider_value);
                    check_field("pending_flags", got.pending_flags, want.pending_flags);
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the timer / interrupt controller: a directed run over the
// field extremes, period zero, wide register writes and interrupt priority,
// then randomized register settings with random instruction streams, random
// idling on both channels, one long output hold-off and one sender pause.
// Checking is done by tic_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import tic_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // cycles[5:0] ext_requests[10:6] set_master_enable[11]
                            // current_pc[27:12] zero[31:28]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // service[0] vector[8:1] return_address[24:9] wake[25]
                            // timer_value[33:26] divider_value[41:34]
                            // pending_flags[46:42] zero[47]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int chk_errors;
    int chk_outstanding;
    int chk_results;
    int chk_services;
    int chk_overflows;

    bit calm;
    int hold_asked;
    int settings_used;

    timer_interrupt_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tic_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .errors         (chk_errors),
        .outstanding    (chk_outstanding),
        .results_seen   (chk_results),
        .services_seen  (chk_services),
        .overflows_seen (chk_overflows)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", chk_outstanding);
        $display("Simulation FAILED");
        $finish;
    end

    // output side: random stalls, long hold-off on request, none when calm
    initial
    begin
        int  stall_left;
        int  run_left;
        int  hold_left;
        int  hold_served;
        bit  rdy;
        stall_left  = 0;
        run_left    = 0;
        hold_left   = 0;
        hold_served = 0;
        m_tready    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left   = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (calm)
            begin
                rdy = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                rdy = 1'b1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                rdy = 1'b0;
            end
            else
            begin
                run_left = $urandom_range(1, 30) - 1;
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    task automatic send_txn(logic [5:0] cyc, logic [4:0] ext, logic sme, logic [15:0] pc);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, pc, sme, ext, cyc};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_txn();
        logic [5:0]  cyc;
        logic [4:0]  ext;
        int          sel;
        sel = $urandom_range(0, 9);
        cyc = (sel == 0) ? 6'd0 : (sel == 1) ? 6'd63 : 6'($urandom_range(0, 63));
        sel = $urandom_range(0, 9);
        ext = (sel < 6) ? 5'd0 : (sel < 8) ? 5'(1 << $urandom_range(0, 4))
                                           : 5'($urandom_range(0, 31));
        send_txn(cyc, ext, $urandom_range(0, 3) == 0, 16'($urandom));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (chk_outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // upper bits are junk so that the register keeps only its own width
    task automatic reg_write(tic_reg_t r, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_settings(int period, int en, int reload, int irq_en);
        reg_write(REG_TIMER_PERIOD, (32'($urandom) << PERIOD_W) | 32'(period));
        reg_write(REG_TIMER_ENABLE, (32'($urandom) << 1) | 32'(en));
        reg_write(REG_TIMER_RELOAD, (32'($urandom) << COUNT_W) | 32'(reload));
        reg_write(REG_INTERRUPT_ENABLE, (32'($urandom) << IRQ_W) | 32'(irq_en));
        settings_used++;
    endtask

    initial
    begin
        int period;
        int reload;
        int irq_en;
        int n;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        hold_asked    = 0;
        settings_used = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: timer off, nothing enabled, flags collect
        send_txn(6'd0, 5'd0, 1'b0, 16'h0000);
        send_txn(6'd63, 5'h1F, 1'b0, 16'hFFFF);
        wait_for_results();

        // all-ones writes but for period zero, which ticks every item
        reg_write(REG_INTERRUPT_ENABLE, 32'hFFFF_FFFF);
        reg_write(REG_TIMER_PERIOD, 32'hFFFF_F800);
        reg_write(REG_TIMER_ENABLE, 32'hFFFF_FFFF);
        reg_write(REG_TIMER_RELOAD, 32'hFFFF_FFFF);
        settings_used++;
        // priority order: bits 0..4 serviced one per enable
        send_txn(6'd1, 5'd0, 1'b1, 16'h1234);
        send_txn(6'd63, 5'd0, 1'b1, 16'hFFFF);
        send_txn(6'd0, 5'd0, 1'b1, 16'h0000);
        send_txn(6'd32, 5'd0, 1'b1, 16'h8001);
        send_txn(6'd17, 5'd0, 1'b1, 16'h7FFE);
        send_txn(6'd5, 5'd0, 1'b0, 16'hAAAA);     // nothing pending: zero vector
        send_txn(6'd63, 5'h10, 1'b0, 16'h5555);   // wake without master enable
        send_txn(6'd63, 5'd0, 1'b1, 16'hC3C3);
        wait_for_results();

        reg_write(REG_TIMER_PERIOD, 32'hFFFF_FFFF);
        settings_used++;
        repeat (3) send_txn(6'd63, 5'd0, 1'b0, 16'h0F0F);
        wait_for_results();

        // flags pending but masked: no wake, master enable stays set
        reg_write(REG_INTERRUPT_ENABLE, 32'h0000_0000);
        settings_used++;
        send_txn(6'd63, 5'h1F, 1'b1, 16'hF00F);
        send_txn(6'd0, 5'd0, 1'b0, 16'h00FF);
        wait_for_results();

        for (int p = 0; p < 7; p++)
        begin
            if (p == 0)
            begin
                load_settings(1, 1, 252, 31);
                n = 260;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: period = 0;
                    1: period = 1;
                    2: period = 2047;
                    3: period = 1024;
                    4: period = $urandom_range(1, 1024);
                    default: period = $urandom_range(1, 2047);
                endcase
                case ($urandom_range(0, 2))
                    0: reload = 0;
                    1: reload = 255;
                    default: reload = $urandom_range(0, 255);
                endcase
                case ($urandom_range(0, 2))
                    0: irq_en = 0;
                    1: irq_en = 31;
                    default: irq_en = $urandom_range(0, 31);
                endcase
                load_settings(period, $urandom_range(0, 3) != 0, reload, irq_en);
                n = 40;
            end
            calm = (p == 6);
            for (int i = 0; i < n; i++)
            begin
                if (p == 0 && i == 40)
                    hold_asked++;
                if (p == 0 && i == 150)
                    wait_for_results();
                send_random_txn();
            end
            wait_for_results();
        end

        repeat (10) @(negedge clk);
        $display("Checked %0d results over %0d register settings", chk_results, settings_used);
        $display("Interrupts serviced: %0d, timer overflows: %0d", chk_services, chk_overflows);
        if (chk_errors == 0 && chk_outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
